// ----- rtl/core/stable_quadratic_roots_unit_assert.svh -----
// Assertion macros for the stable quadratic roots unit.
// Depends on nothing; included by the top level, which provides aclk and aresetn.
`ifndef STABLE_QUADRATIC_ROOTS_UNIT_ASSERT_SVH
`define STABLE_QUADRATIC_ROOTS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SQRU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SQRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SQRU_ASSERT_IMPL(lbl, ante, cons)
`define SQRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/sqru_pkg.sv -----
// Shared constants and types for the stable quadratic roots unit.
// No dependencies.
package sqru_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 32;
    localparam int SW         = COEF_WIDTH + 1;              // sqrt result bits
    localparam int MQW        = COEF_WIDTH + 2;              // |q2| bits
    localparam int RW         = 2 * COEF_WIDTH + FRAC_BITS + 4; // divider datapath
    localparam int QDEPTH     = 4;
    localparam int QPW        = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CLS_NEG,
        CLS_ZERO,
        CLS_ROOTS
    } cls_t;

    // front to back queue entry
    typedef struct packed {
        cls_t                    cls;
        logic                    nq;
        logic                    na;
        logic                    nc;
        logic [COEF_WIDTH-1:0]   ma;
        logic [COEF_WIDTH-1:0]   mc;
        logic [MQW-1:0]          mq;
    } qe_t;

    // queue status toward its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;
endpackage

// ----- rtl/core/sqru_front.sv -----
// Front part: magnitudes, discriminant, pipelined square root, classification.
// Depends on sqru_pkg.
module sqru_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] coef_a,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] coef_b,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] coef_c,
    output logic                                   push,
    output sqru_pkg::qe_t                          push_data,
    input  sqru_pkg::qstat_t                       qstat
);
    localparam int W = sqru_pkg::COEF_WIDTH;
    localparam int SW = sqru_pkg::SW;

    typedef struct packed {
        logic         na;
        logic         nb;
        logic         nc;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] mc;
    } mg_t;

    typedef struct packed {
        mg_t              mg;
        logic             neg;
        logic [2*SW-1:0]  rad;
        logic [SW+1:0]    rem;
        logic [SW-1:0]    root;
    } fs_t;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    // one result bit of the digit-by-digit square root
    function automatic fs_t sq_step(input fs_t s);
        fs_t          r;
        logic [SW+3:0] tmp;
        logic [SW+3:0] trial;
        r     = s;
        tmp   = {s.rem, s.rad[2*SW-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        if (tmp >= trial) begin
            r.rem  = (SW+2)'(tmp - trial);
            r.root = {s.root[SW-2:0], 1'b1};
        end else begin
            r.rem  = (SW+2)'(tmp);
            r.root = {s.root[SW-2:0], 1'b0};
        end
        r.rad = {s.rad[2*SW-3:0], 2'b00};
        return r;
    endfunction

    logic             en;
    logic             s1v_reg, s2v_reg;
    mg_t              s1_reg, s2_reg;
    logic [2*W-1:0]   b2_reg, p_reg;
    logic [SW:0]      sqv_reg;
    fs_t              sq_reg [0:SW];
    fs_t              st0;
    logic             ac_neg;
    logic [2*W+1:0]   b2x, fac;
    logic [sqru_pkg::MQW-1:0] mq;

    assign en       = !sqv_reg[SW] || !qstat.full;
    assign in_ready = en;
    assign push     = sqv_reg[SW] && !qstat.full;

    always_comb begin
        ac_neg = (s2_reg.ma != '0) && (s2_reg.mc != '0) && (s2_reg.na != s2_reg.nc);
        b2x    = {2'b00, b2_reg};
        fac    = {p_reg, 2'b00};
        st0      = '0;
        st0.mg   = s2_reg;
        st0.neg  = !ac_neg && (fac > b2x);
        st0.rad  = ac_neg ? (b2x + fac) : (b2x - fac);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
            sqv_reg <= '0;
        end else if (en) begin
            s1v_reg <= in_valid;
            s2v_reg <= s1v_reg;
            sqv_reg <= {sqv_reg[SW-1:0], s2v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.na <= coef_a[W-1];
            s1_reg.nb <= coef_b[W-1];
            s1_reg.nc <= coef_c[W-1];
            s1_reg.ma <= mag(coef_a);
            s1_reg.mb <= mag(coef_b);
            s1_reg.mc <= mag(coef_c);
            s2_reg    <= s1_reg;
            b2_reg    <= (2*W)'(s1_reg.mb) * (2*W)'(s1_reg.mb);
            p_reg     <= (2*W)'(s1_reg.ma) * (2*W)'(s1_reg.mc);
            sq_reg[0] <= st0;
            for (int k = 0; k < SW; k++) begin
                sq_reg[k+1] <= sq_step(sq_reg[k]);
            end
        end
    end

    // classify the finished item
    always_comb begin
        mq = sqru_pkg::MQW'(sq_reg[SW].mg.mb) + sqru_pkg::MQW'(sq_reg[SW].root);
        push_data.nq = !sq_reg[SW].mg.nb;
        push_data.na = sq_reg[SW].mg.na;
        push_data.nc = sq_reg[SW].mg.nc;
        push_data.ma = sq_reg[SW].mg.ma;
        push_data.mc = sq_reg[SW].mg.mc;
        push_data.mq = mq;
        if (sq_reg[SW].neg) begin
            push_data.cls = sqru_pkg::CLS_NEG;
        end else if (mq == '0 || sq_reg[SW].mg.ma == '0) begin
            push_data.cls = sqru_pkg::CLS_ZERO;
        end else begin
            push_data.cls = sqru_pkg::CLS_ROOTS;
        end
    end
endmodule

// ----- rtl/core/sqru_queue.sv -----
// Short queue of classified items between front and back.
// Depends on sqru_pkg.
module sqru_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sqru_pkg::qe_t    push_data,
    input  logic             pop,
    output sqru_pkg::qe_t    head,
    output sqru_pkg::qstat_t qstat
);
    localparam int D = sqru_pkg::QDEPTH;
    localparam int PW = sqru_pkg::QPW;

    sqru_pkg::qe_t  mem_reg [0:D-1];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;
    logic           do_push, do_pop;

    assign qstat.full  = (cnt_reg == (PW+1)'(D));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wp_reg <= wp_reg + PW'(1);
            if (do_pop)  rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wp_reg] <= push_data;
    end
endmodule

// ----- rtl/core/sqru_back.sv -----
// Back part: two pipelined restoring dividers, saturation, result sequencing.
// Depends on sqru_pkg.
module sqru_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    output logic                                   pop,
    input  sqru_pkg::qe_t                          head,
    input  sqru_pkg::qstat_t                       qstat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [sqru_pkg::COEF_WIDTH-1:0] root_value,
    output logic                                   status,
    output logic                                   saturated,
    output logic                                   last_result
);
    localparam int W  = sqru_pkg::COEF_WIDTH;
    localparam int F  = sqru_pkg::FRAC_BITS;
    localparam int RW = sqru_pkg::RW;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dsh;
        logic [W-1:0]  q;
        logic          ovf;
    } dv_t;

    typedef struct packed {
        sqru_pkg::cls_t cls;
        logic           neg1;
        logic           neg2;
        dv_t            d1;
        dv_t            d2;
    } bs_t;

    typedef struct packed {
        logic [W-1:0] r1;
        logic [W-1:0] r2;
        logic         sat1;
        logic         sat2;
        logic         st;
        logic         two;
    } hold_t;

    function automatic dv_t dv_init(input logic [RW-1:0] n, input logic [RW-1:0] d);
        dv_t r;
        r.rem = n;
        r.ovf = (n >= (d << W));
        r.dsh = d << (W-1);
        r.q   = '0;
        return r;
    endfunction

    function automatic dv_t dv_step(input dv_t s);
        dv_t r;
        r = s;
        if (s.rem >= s.dsh) begin
            r.rem = s.rem - s.dsh;
            r.q   = {s.q[W-2:0], 1'b1};
        end else begin
            r.q   = {s.q[W-2:0], 1'b0};
        end
        r.dsh = s.dsh >> 1;
        return r;
    endfunction

    function automatic logic [W:0] fin(input dv_t s, input logic neg);
        logic [W-1:0] lim, v;
        logic         sat;
        lim = neg ? HALF : (HALF - W'(1));
        sat = s.ovf || (s.q > lim);
        v   = sat ? lim : s.q;
        fin = {sat, neg ? (~v + W'(1)) : v};
    endfunction

    logic          en;
    logic [W:0]    bv_reg;
    bs_t           bs_reg [0:W];
    bs_t           b0;
    hold_t         hold_reg, hold_new;
    logic          hv_reg, idx_reg;
    logic [W:0]    f1, f2;

    assign last_result = !hold_reg.two || idx_reg;
    assign en          = !hv_reg || (out_ready && last_result);
    assign pop         = en && !qstat.empty;
    assign out_valid   = hv_reg;
    assign root_value  = idx_reg ? hold_reg.r2 : hold_reg.r1;
    assign saturated   = idx_reg ? hold_reg.sat2 : hold_reg.sat1;
    assign status      = hold_reg.st;

    always_comb begin
        b0.cls  = head.cls;
        b0.neg1 = head.nq ^ head.na;
        b0.neg2 = head.nc ^ head.nq;
        b0.d1   = dv_init(RW'(head.mq) << F, RW'(head.ma) << 1);
        b0.d2   = dv_init(RW'(head.mc) << (F+1), RW'(head.mq));
    end

    always_comb begin
        f1 = fin(bs_reg[W].d1, bs_reg[W].neg1);
        f2 = fin(bs_reg[W].d2, bs_reg[W].neg2);
        hold_new = '0;
        case (bs_reg[W].cls)
            sqru_pkg::CLS_NEG: begin
                hold_new.st = 1'b1;
            end
            sqru_pkg::CLS_ROOTS: begin
                hold_new.r1   = f1[W-1:0];
                hold_new.sat1 = f1[W];
                hold_new.r2   = f2[W-1:0];
                hold_new.sat2 = f2[W];
                hold_new.two  = (f1[W-1:0] != f2[W-1:0]);
            end
            default: begin
                hold_new = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg  <= '0;
            hv_reg  <= 1'b0;
            idx_reg <= 1'b0;
        end else begin
            if (en) begin
                bv_reg  <= {bv_reg[W-1:0], pop};
                hv_reg  <= bv_reg[W];
                idx_reg <= 1'b0;
            end else if (out_ready) begin
                idx_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bs_reg[0] <= b0;
            for (int k = 0; k < W; k++) begin
                bs_reg[k+1].cls  <= bs_reg[k].cls;
                bs_reg[k+1].neg1 <= bs_reg[k].neg1;
                bs_reg[k+1].neg2 <= bs_reg[k].neg2;
                bs_reg[k+1].d1   <= dv_step(bs_reg[k].d1);
                bs_reg[k+1].d2   <= dv_step(bs_reg[k].d2);
            end
            hold_reg <= hold_new;
        end
    end
endmodule

// ----- rtl/core/stable_quadratic_roots_unit.sv -----
// Top level of the stable quadratic roots unit.
// Depends on sqru_pkg, sqru_front, sqru_queue, sqru_back and the assertion header.
//
// Usage:
//   Input channel s_*: one request carries coefficients a, b, c in signed
//   Q16.16, taken when s_valid and s_ready are both high.
//   Result channel m_*: one or two results per request. A negative
//   discriminant gives one result with m_status set. Zero a or zero q
//   gives one root of 0. Distinct roots give q/a first (m_last_result 0)
//   and then c/q (m_last_result 1); equal roots give just one.
//   m_saturated marks a root clamped to the Q16.16 range.
// Timing:
//   The path runs through a magnitude register, a product register, a
//   square root with one stage per result bit, then two dividers with one
//   stage per quotient bit and a result register; items may wait in the queue.
//   A request may enter every cycle while s_ready is high; the result
//   channel sets the sustained rate, and a request with two roots gives two results.
// Reset and stalls:
//   aresetn (synchronous, active low) empties all stages and the queue.
//   When the receiver stalls, the back pipeline holds, the queue fills, and
//   then s_ready drops; no result is lost.
`include "stable_quadratic_roots_unit_assert.svh"
module stable_quadratic_roots_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] s_coef_a,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] s_coef_b,
    input  logic signed [sqru_pkg::COEF_WIDTH-1:0] s_coef_c,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sqru_pkg::COEF_WIDTH-1:0] m_root_value,
    output logic                                   m_status,
    output logic                                   m_saturated,
    output logic                                   m_last_result
);
    logic             push, pop;
    sqru_pkg::qe_t    push_data, head;
    sqru_pkg::qstat_t qstat;

    // front: classify and take the square root
    sqru_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .coef_a    (s_coef_a),
        .coef_b    (s_coef_b),
        .coef_c    (s_coef_c),
        .push      (push),
        .push_data (push_data),
        .qstat     (qstat)
    );

    // decoupling queue
    sqru_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // back: divide, saturate, emit one or two results
    sqru_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .head        (head),
        .qstat       (qstat),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .root_value  (m_root_value),
        .status      (m_status),
        .saturated   (m_saturated),
        .last_result (m_last_result)
    );

    // no-real-roots result is always a lone zero
    `SQRU_ASSERT_IMPL(a_neg_lone, m_valid && m_status, m_last_result && m_root_value == '0)
    // a clamped root never comes with no-real-roots
    `SQRU_ASSERT_IMPL(a_sat_valid, m_valid && m_saturated, !m_status)
    // first of two roots taken: the second follows at once
    `SQRU_ASSERT_NEXT(a_second, m_valid && m_ready && !m_last_result, m_valid && m_last_result)
endmodule

// ----- test/stable_quadratic_roots_unit_tb.sv -----
// Testbench for stable_quadratic_roots_unit: directed and random coefficient requests,
// predicted roots compared field by field against the result channel.
// Depends on sqru_pkg and the stable_quadratic_roots_unit RTL.
module stable_quadratic_roots_unit_tb;
    localparam int W         = sqru_pkg::COEF_WIDTH;
    localparam int FRAC_BITS = sqru_pkg::FRAC_BITS;
    localparam int N_RANDOM  = 750;
    localparam int IDLE_MAX  = 20000;   // cycles with no handshake before giving up
    localparam int DRAIN     = 2 * W + 40;

    typedef struct {
        logic signed [W-1:0] root;
        logic                status;
        logic                sat;
        logic                last;
    } root_res_t;

    // Expected roots for every accepted request, oldest first.
    class root_scoreboard;
        root_res_t pending_roots[$];
        int        n_errors;
        int        n_checked;
        int        n_two;
        int        n_neg;
        int        n_sat;

        function new();
            n_errors  = 0;
            n_checked = 0;
            n_two     = 0;
            n_neg     = 0;
            n_sat     = 0;
        endfunction

        function void append_root(root_res_t r);
            pending_roots.insert(pending_roots.size(), r);
        endfunction

        // Truncated signed quotient (num * 2^FRAC_BITS) / den, clamped to W bits.
        function logic [W:0] fixed_quot(logic [127:0] num, logic [127:0] den,
                                        logic neg);
            logic [127:0] q;
            logic [127:0] lim;
            logic         sat;
            q   = (num << FRAC_BITS) / den;
            lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
            sat = 1'b0;
            if (q > lim) begin
                q   = lim;
                sat = 1'b1;
            end
            if (neg) q = -q;
            return {sat, q[W-1:0]};
        endfunction

        function logic [127:0] isqrt(logic [127:0] d);
            logic [127:0] r;
            logic [127:0] t;
            r = 0;
            for (int i = 63; i >= 0; i--) begin
                t = r | (128'd1 << i);
                if (t * t <= d) r = t;
            end
            return r;
        endfunction

        function void note_request(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                   logic signed [W-1:0] c);
            logic         na, nb, nc, nq;
            logic [127:0] ma, mb, mc, b2, fac, disc, s, mq;
            logic [W:0]   q1, q2;
            root_res_t    r;
            na = a[W-1]; nb = b[W-1]; nc = c[W-1];
            ma = na ? 128'(-$signed({a[W-1], a})) : 128'(a);
            mb = nb ? 128'(-$signed({b[W-1], b})) : 128'(b);
            mc = nc ? 128'(-$signed({c[W-1], c})) : 128'(c);
            ma = ma & ((128'd1 << W) - 1) | (na && a == {1'b1, {(W-1){1'b0}}} ?
                                              (128'd1 << (W - 1)) : 0);
            mb = mb & ((128'd1 << W) - 1) | (nb && b == {1'b1, {(W-1){1'b0}}} ?
                                              (128'd1 << (W - 1)) : 0);
            mc = mc & ((128'd1 << W) - 1) | (nc && c == {1'b1, {(W-1){1'b0}}} ?
                                              (128'd1 << (W - 1)) : 0);
            b2  = mb * mb;
            fac = (ma << 2) * mc;
            if (ma != 0 && mc != 0 && na != nc) begin
                disc = b2 + fac;
            end else if (fac > b2) begin
                r = '{root: '0, status: 1'b1, sat: 1'b0, last: 1'b1};
                append_root(r);
                n_neg++;
                return;
            end else begin
                disc = b2 - fac;
            end
            s  = isqrt(disc);
            mq = mb + s;
            nq = !nb;
            if (mq == 0 || ma == 0) begin
                r = '{root: '0, status: 1'b0, sat: 1'b0, last: 1'b1};
                append_root(r);
                return;
            end
            q1 = fixed_quot(mq, ma << 1, nq != na);
            q2 = (mc == 0) ? '0 : fixed_quot(mc << 1, mq, nc != nq);
            if (q1[W] || q2[W]) n_sat++;
            if (q1[W-1:0] == q2[W-1:0]) begin
                r = '{root: q1[W-1:0], status: 1'b0, sat: q1[W], last: 1'b1};
                append_root(r);
            end else begin
                r = '{root: q1[W-1:0], status: 1'b0, sat: q1[W], last: 1'b0};
                append_root(r);
                r = '{root: q2[W-1:0], status: 1'b0, sat: q2[W], last: 1'b1};
                append_root(r);
                n_two++;
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            n_errors++;
        endtask

        task check_root(root_res_t got);
            root_res_t want;
            n_checked++;
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h", got.root));
                return;
            end
            want = pending_roots.pop_front();
            if (got.root !== want.root)
                report_mismatch($sformatf("root %h, want %h", got.root, want.root));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
            if (got.sat !== want.sat)
                report_mismatch($sformatf("saturated %b, want %b", got.sat, want.sat));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic signed [W-1:0] s_coef_a;
    logic signed [W-1:0] s_coef_b;
    logic signed [W-1:0] s_coef_c;
    logic                m_valid;
    logic                m_ready;
    logic signed [W-1:0] m_root_value;
    logic                m_status;
    logic                m_saturated;
    logic                m_last_result;

    stable_quadratic_roots_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coef_a      (s_coef_a),
        .s_coef_b      (s_coef_b),
        .s_coef_c      (s_coef_c),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_root_value  (m_root_value),
        .m_status      (m_status),
        .m_saturated   (m_saturated),
        .m_last_result (m_last_result)
    );

    root_scoreboard sb = new();
    int  idle_cycles = 0;
    int  n_requests  = 0;
    bit  long_stall  = 1'b0;   // set by stimulus, receiver holds m_ready low
    bit  stall_done  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Reference both channels at the edge; everything sampled here sees pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_coef_a, s_coef_b, s_coef_c);
                n_requests++;
            end
            if (m_valid && m_ready)
                sb.check_root('{root: m_root_value, status: m_status,
                               sat: m_saturated, last: m_last_result});
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (!s_valid && sb.pending_roots.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("timeout: no handshake for %0d cycles", IDLE_MAX);
                $display("stable_quadratic_roots_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    initial begin
        int mode;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_stall && !stall_done) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                stall_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                case (mode)
                    0: m_ready <= 1'b1;                          // no stalls
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 1) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // One request: valid held with stable payload until accepted.
    task automatic send_request(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                logic signed [W-1:0] c);
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_roots.size() != 0) @(posedge aclk);
    endtask

    // Mostly small coefficients so real roots and divisions stay interesting.
    function automatic logic signed [W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return '0;
            2:       return {1'b1, {(W-1){1'b0}}};
            3:       return {1'b0, {(W-1){1'b1}}};
            4:       return $signed($urandom_range(0, 8)) <<< FRAC_BITS;
            5:       return -($signed($urandom_range(0, 8)) <<< FRAC_BITS);
            default: return $signed($urandom()) >>> $urandom_range(4, 24);
        endcase
    endfunction

    localparam logic signed [W-1:0] ONE  = 1 <<< FRAC_BITS;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    initial begin
        logic signed [W-1:0] a, b, c;
        int burst;
        s_valid  <= 1'b0;
        s_coef_a <= '0;
        s_coef_b <= '0;
        s_coef_c <= '0;
        aresetn  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // Directed: distinct roots, equal roots, negative discriminant,
        // zero a, zero q, zero c, saturation both ways, extreme values.
        send_request(ONE, -3 * ONE, 2 * ONE);     // roots 1 and 2
        send_request(ONE, -2 * ONE, ONE);         // double root
        send_request(ONE, '0, ONE);               // no real roots
        send_request('0, 2 * ONE, ONE);           // a = 0
        send_request(ONE, '0, '0);                // q = 0
        send_request(ONE, ONE, '0);               // c = 0
        send_request(-ONE, 5 * ONE, 6 * ONE);
        send_request(32'sd1, MAXV, ONE);          // huge root, saturates
        send_request(32'sd1, MINV, ONE);
        send_request(MAXV, MAXV, MAXV);
        send_request(MINV, MINV, MINV);
        send_request(MINV, MAXV, MAXV);
        send_request(MAXV, MINV, MINV);
        send_request(32'sd1, '0, MINV);           // both clamp
        send_request(32'sd1, '0, MAXV);
        send_request(-1, -1, -1);
        send_request(32'sd1, 32'sd1, 32'sd1);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request('0, '0, '0);
        wait_drained();                           // sender pause until all came back

        // Long receiver stall while the sender keeps offering requests.
        long_stall = 1'b1;
        while (!stall_done) begin
            send_request(rand_coef(), rand_coef(), rand_coef());
        end
        s_valid <= 1'b0;

        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
                a = rand_coef();
                b = rand_coef();
                c = rand_coef();
                if ($urandom_range(0, 3) == 0) begin
                    // build from integer roots: a(x-r1)(x-r2)
                    int r1, r2, ka;
                    r1 = $urandom_range(0, 40) - 20;
                    r2 = $urandom_range(0, 40) - 20;
                    ka = $urandom_range(1, 6) * ($urandom_range(0, 1) ? 1 : -1);
                    a  = ka <<< FRAC_BITS;
                    b  = (-ka * (r1 + r2)) <<< FRAC_BITS;
                    c  = (ka * r1 * r2) <<< FRAC_BITS;
                end
                send_request(a, b, c);
            end
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end

        wait_drained();
        repeat (DRAIN) @(posedge aclk);
        $display("covered %0d requests, %0d results: %0d two-root, %0d no-real-root, %0d clamped",
                 n_requests, sb.n_checked, sb.n_two, sb.n_neg, sb.n_sat);
        if (sb.n_errors == 0 && sb.pending_roots.size() == 0) begin
            $display("stable_quadratic_roots_unit_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.n_errors,
                     sb.pending_roots.size());
            $display("stable_quadratic_roots_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
